>>> rtl/pnsf_pkg.sv
package pnsf_pkg;

	localparam int unsigned NUM_SECTIONS = 6;
	localparam int unsigned SAMPLE_W     = 16;
	localparam int unsigned STATE_W      = 32;
	localparam int unsigned COEF_W       = 18;
	localparam int unsigned PROD_W       = STATE_W + COEF_W;
	localparam int unsigned SUM_W        = 36;
	localparam int unsigned STEP_W       = 4;

	// sequencer steps: even steps below STEP_DIRECT are decays, odd ones white feeds
	localparam logic [STEP_W-1:0] STEP_DIRECT = 4'd12;
	localparam logic [STEP_W-1:0] STEP_DELAY  = 4'd13;
	localparam logic [STEP_W-1:0] STEP_SCALE  = 4'd14;
	localparam logic [STEP_W-1:0] STEP_LAST   = 4'd15;

	typedef logic signed [COEF_W-1:0] coef_t;

	localparam coef_t POLE_COEF [NUM_SECTIONS] = '{
		18'sd130923, 18'sd130196, 18'sd127009, 18'sd113574, 18'sd72090, -18'sd99824
	};
	localparam coef_t FEED_COEF [NUM_SECTIONS] = '{
		18'sd7277, 18'sd9840, 18'sd20166, 18'sd40696, 18'sd69855, -18'sd2215
	};
	localparam coef_t DIRECT_COEF = 18'sd70281;
	localparam coef_t DELAY_COEF  = 18'sd15195;
	localparam coef_t SCALE_COEF  = 18'sd14418;

	typedef struct packed {
		logic              idle;
		logic              issue;
		logic [STEP_W-1:0] step;
		logic              post;
		logic [STEP_W-1:0] post_step;
		logic              hold;
	} ctl_t;

	function automatic coef_t coef_of(input logic [STEP_W-1:0] step);
		coef_t c;
		c = '0;
		if (step < STEP_DIRECT) begin
			if (step[0])
				c = FEED_COEF[step[3:1]];
			else
				c = POLE_COEF[step[3:1]];
		end else if (step == STEP_DIRECT) begin
			c = DIRECT_COEF;
		end else if (step == STEP_DELAY) begin
			c = DELAY_COEF;
		end else begin
			c = SCALE_COEF;
		end
		return c;
	endfunction

endpackage

>>> rtl/pink_noise_shaping_filter_unit.sv
// pink noise shaping filter, refined six-section leaky integrator bank
//
// channels
//   s_axis: one white sample per transaction, signed Q1.15
//   m_axis: one noise sample per input transaction, signed Q1.15, saturated
//   cfg:    one-bit color mode write, 0 = white pass-through, 1 = pink;
//           always ready, write only while no item is in flight
//
// sequencing
//   white mode: the sample is registered and passed through the hold state
//   into the output register, which raises m_axis_tvalid; the next input is
//   taken only after that load
//   pink mode: one shared 32x18 multiplier runs 15 products (decay and feed
//   per section, direct, delay, scale) under a 16-step counter, then the hold
//   state loads the output register once the slot is free; the next input is
//   taken only after that load
//
// reset clears mode, section accumulators and the delayed term to zero
// a stalled receiver holds the output register; the next item is still
// accepted and computed, and waits for the output slot before finishing
module pink_noise_shaping_filter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] white_sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] noise_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_data        // [0] color_mode
);

	localparam int unsigned SW = pnsf_pkg::STATE_W;
	localparam int unsigned PW = pnsf_pkg::PROD_W;
	localparam int unsigned UW = pnsf_pkg::SUM_W;

	pnsf_pkg::ctl_t ctl;

	logic                 mode_q;
	logic signed [15:0]   w_q;
	logic signed [SW-1:0] acc_q [pnsf_pkg::NUM_SECTIONS];
	logic signed [SW-1:0] delayed_q;
	logic signed [SW:0]   decay_q;
	logic signed [UW-1:0] sum_q;
	logic [15:0]          res_q;

	logic                 s_xact;
	logic                 out_free;
	logic [2:0]           rd_idx;
	logic signed [SW-1:0] mul_a;
	pnsf_pkg::coef_t      mul_b;
	logic signed [PW-1:0] prod;

	// post-multiply rounding paths
	logic signed [PW-1:0] rnd_decay;
	logic signed [PW-1:0] rnd_white;
	logic signed [PW-1:0] rnd_scale;
	logic signed [SW:0]   white_term;
	logic signed [SW+1:0] sect_sum;
	logic signed [SW-1:0] sect_new;
	logic signed [23:0]   y_full;
	logic [15:0]          y_sat;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = ctl.idle;
	assign s_xact        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	pnsf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_white (s_xact && !mode_q),
		.start_pink  (s_xact && mode_q),
		.out_free    (out_free),
		.ctl         (ctl)
	);

	// operand select: section state for decays, clamped sum for scale, else sample
	always_comb begin
		rd_idx = (ctl.step < pnsf_pkg::STEP_DIRECT) ? ctl.step[3:1] : 3'd0;
		if (ctl.step < pnsf_pkg::STEP_DIRECT && !ctl.step[0]) begin
			mul_a = acc_q[rd_idx];
		end else if (ctl.step == pnsf_pkg::STEP_SCALE) begin
			if (sum_q > UW'(signed'(32'sh7FFFFFFF)))
				mul_a = 32'sh7FFFFFFF;
			else if (sum_q < UW'(signed'(32'sh80000000)))
				mul_a = 32'sh80000000;
			else
				mul_a = sum_q[SW-1:0];
		end else begin
			mul_a = SW'(w_q);
		end
		mul_b = pnsf_pkg::coef_of(ctl.step);
	end

	pnsf_mul u_mul (
		.clk (clk),
		.en  (ctl.issue),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	always_comb begin
		rnd_decay  = prod + PW'(65536);
		rnd_white  = prod + PW'(128);
		rnd_scale  = prod + PW'(33554432);
		white_term = rnd_white[SW+8:8];
		sect_sum   = (SW+2)'(decay_q) + (SW+2)'(white_term);
		if (sect_sum > (SW+2)'(signed'(32'sh7FFFFFFF)))
			sect_new = 32'sh7FFFFFFF;
		else if (sect_sum < (SW+2)'(signed'(32'sh80000000)))
			sect_new = 32'sh80000000;
		else
			sect_new = sect_sum[SW-1:0];
		y_full = rnd_scale[PW-1:26];
		if (y_full > 24'sd32767)
			y_sat = 16'h7FFF;
		else if (y_full < -24'sd32768)
			y_sat = 16'h8000;
		else
			y_sat = y_full[15:0];
	end

	// filter state, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			delayed_q <= '0;
			for (int i = 0; i < pnsf_pkg::NUM_SECTIONS; i++)
				acc_q[i] <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				mode_q <= cfg_data[0];
			if (ctl.post && ctl.post_step < pnsf_pkg::STEP_DIRECT && ctl.post_step[0])
				acc_q[ctl.post_step[3:1]] <= sect_new;
			if (ctl.post && ctl.post_step == pnsf_pkg::STEP_DELAY)
				delayed_q <= white_term[SW-1:0];
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (s_xact) begin
			w_q   <= s_axis_tdata;
			res_q <= s_axis_tdata;
			sum_q <= UW'(delayed_q);
		end
		if (ctl.post) begin
			if (ctl.post_step < pnsf_pkg::STEP_DIRECT) begin
				if (ctl.post_step[0])
					sum_q <= sum_q + UW'(sect_new);
				else
					decay_q <= rnd_decay[PW-1:17];
			end else if (ctl.post_step == pnsf_pkg::STEP_DIRECT) begin
				sum_q <= sum_q + UW'(white_term);
			end else if (ctl.post_step == pnsf_pkg::STEP_SCALE) begin
				res_q <= y_sat;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (ctl.hold && out_free) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.hold && out_free)
			m_axis_tdata <= res_q;
	end

endmodule

>>> rtl/pnsf_mul.sv
module pnsf_mul (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [pnsf_pkg::STATE_W-1:0]    a,
	input  pnsf_pkg::coef_t                        b,
	output logic signed [pnsf_pkg::PROD_W-1:0]     p_q
);

	// shared 32x18 multiplier, product registered
	always_ff @(posedge clk) begin
		if (en)
			p_q <= a * b;
	end

endmodule

>>> rtl/pnsf_ctrl.sv
module pnsf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start_white,
	input  logic           start_pink,
	input  logic           out_free,
	output pnsf_pkg::ctl_t ctl
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t                      state_q;
	logic [pnsf_pkg::STEP_W-1:0] step_q;
	logic                        post_q;
	logic [pnsf_pkg::STEP_W-1:0] post_step_q;
	logic                        issue;

	assign issue = (state_q == ST_RUN) && (step_q != pnsf_pkg::STEP_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			post_q      <= 1'b0;
			post_step_q <= '0;
		end else begin
			post_q      <= issue;
			post_step_q <= step_q;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (start_pink)
						state_q <= ST_RUN;
					else if (start_white)
						state_q <= ST_HOLD;
				end
				ST_RUN: begin
					step_q <= step_q + 4'd1;
					if (step_q == pnsf_pkg::STEP_LAST)
						state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl.idle      = (state_q == ST_IDLE);
		ctl.issue     = issue;
		ctl.step      = step_q;
		ctl.post      = post_q;
		ctl.post_step = post_step_q;
		ctl.hold      = (state_q == ST_HOLD);
	end

endmodule

>>> rtl/pnsf_checker.sv
module pnsf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [0:0]  cfg_data
);

	// stalled output holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	// one item at a time: busy right after an input transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in flight");

	// a result only appears after the block has been busy with an item
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without an accepted input");

	// config port never back-pressures
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind pink_noise_shaping_filter_unit pnsf_checker u_pnsf_checker (.*);
